>>> hw/rtl/bond_price_yield_duration_top_assert.svh
// Assertion macros for the bond pricing block
`ifndef BOND_PRICE_YIELD_DURATION_TOP_ASSERT_SVH
`define BOND_PRICE_YIELD_DURATION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPYD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BPYD_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define BPYD_ASSERT(lbl, prop, msg)
`define BPYD_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/bpyd_pkg.sv
`default_nettype none
package bpyd_pkg;
  localparam int unsigned MAX_YEARS     = 64;
  localparam int unsigned MAX_FREQUENCY = 12;
  localparam int unsigned BISECT_STEPS  = 32;
  localparam int unsigned MAX_N = MAX_YEARS * MAX_FREQUENCY;
  localparam int unsigned NW    = $clog2(MAX_N + 1);
  localparam int unsigned WW    = $clog2(MAX_N * (MAX_N + 1) + 1);
  localparam int unsigned SW    = $clog2(BISECT_STEPS + 1);
  localparam int unsigned QDEPTH = 2;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [39:0] MAX32   = 40'h00_FFFF_FFFF;
  localparam logic [39:0] MAX40   = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MKT_ZERO  = 2'd1,
    ST_FREQ_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [39:0]   face;
    logic [31:0]   crate;
    logic [39:0]   mkt;
    logic [31:0]   req;
    logic          given;
    logic [3:0]    f;
    logic [NW-1:0] n;
    status_e       status;
  } item_t;

  typedef enum logic [5:0] {
    BK_IDLE, BK_CMUL, BK_CDIV, BK_CWAIT, BK_BMID, BK_RWAIT, BK_VWAIT,
    BK_PMUL1, BK_PMUL2, BK_PMUL3, BK_PACC, BK_PFACE, BK_PEND, BK_PCHK,
    BK_FINAL, BK_DINIT, BK_DPC,
    BK_DM1, BK_DM2, BK_DM3, BK_DM4, BK_DM5, BK_DM6, BK_DM7,
    BK_DF1, BK_DF2, BK_DF3, BK_DF4, BK_DF5,
    BK_MAC, BK_MACW, BK_MDW, BK_CVW, BK_CYW, BK_OUT
  } back_state_e;
endpackage
`default_nettype wire

>>> hw/rtl/bpyd_in_if.sv
`default_nettype none
interface bpyd_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] par_amount;
  logic [31:0] annual_coupon;
  logic [39:0] quoted_price;
  logic [6:0]  years_left;
  logic [3:0]  payments_per_year;
  logic [31:0] pricing_yield;
  logic        yield_given;
  modport source (output valid, par_amount, annual_coupon, quoted_price, years_left,
                  payments_per_year, pricing_yield, yield_given, input ready);
  modport sink (input valid, par_amount, annual_coupon, quoted_price, years_left,
                payments_per_year, pricing_yield, yield_given, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bpyd_out_if.sv
`default_nettype none
interface bpyd_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] price;
  logic [31:0] yield_to_maturity;
  logic [31:0] yield_used;
  logic [31:0] mac_duration;
  logic [31:0] modified_duration;
  logic [39:0] convexity;
  logic [31:0] current_yield;
  logic        solve_converged;
  logic [1:0]  status;
  modport source (output valid, price, yield_to_maturity, yield_used, mac_duration,
                  modified_duration, convexity, current_yield, solve_converged, status,
                  input ready);
  modport sink (input valid, price, yield_to_maturity, yield_used, mac_duration,
                modified_duration, convexity, current_yield, solve_converged, status,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bpyd_front.sv
`default_nettype none
module bpyd_front (
  bpyd_in_if.sink        in_i,
  input  logic           full_i,
  output logic           push_o,
  output bpyd_pkg::item_t item_o
);
  import bpyd_pkg::*;

  logic [7:0]  yrs;
  logic [3:0]  fc;
  logic [11:0] nf;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    if ({1'b0, in_i.years_left} > 8'(MAX_YEARS)) begin
      yrs = 8'(MAX_YEARS);
    end else begin
      yrs = {1'b0, in_i.years_left};
    end
    if (in_i.payments_per_year > 4'(MAX_FREQUENCY)) begin
      fc = 4'(MAX_FREQUENCY);
    end else begin
      fc = in_i.payments_per_year;
    end
    nf = 12'(yrs) * 12'(fc);
    item_o.face  = in_i.par_amount;
    item_o.crate = in_i.annual_coupon;
    item_o.mkt   = in_i.quoted_price;
    item_o.req   = in_i.pricing_yield;
    item_o.given = in_i.yield_given;
    item_o.f     = fc;
    item_o.n     = NW'(nf);
    if (in_i.payments_per_year == 4'd0) begin
      item_o.status = ST_FREQ_ZERO;
    end else if (in_i.quoted_price == 40'd0) begin
      item_o.status = ST_MKT_ZERO;
    end else begin
      item_o.status = ST_OK;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/bpyd_queue.sv
`default_nettype none
module bpyd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bpyd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bpyd_pkg::item_t item_o
);
  import bpyd_pkg::*;
  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  item_t         mem_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/bpyd_mul.sv
`default_nettype none
// floor(a * b / 2^32), partial products registered, sum combinational
module bpyd_mul (
  input  logic        clk_i,
  input  logic [39:0] a_i,
  input  logic [32:0] b_i,
  output logic [40:0] res_o
);
  logic [63:0] p0_q;
  logic [40:0] p1_q;
  logic [31:0] p2_q;

  always_ff @(posedge clk_i) begin
    p0_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    p1_q <= 41'(a_i[39:32]) * 41'(b_i);
    p2_q <= b_i[32] ? a_i[31:0] : 32'd0;
  end

  assign res_o = p1_q + 41'(p0_q[63:32]) + 41'(p2_q);
endmodule
`default_nettype wire

>>> hw/rtl/bpyd_div.sv
`default_nettype none
// floor(num * 2^sh / den) saturated at maxv, one quotient bit per cycle
module bpyd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] num_i,
  input  logic [5:0]  sh_i,
  input  logic [39:0] den_i,
  input  logic [39:0] maxv_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [39:0] q_o
);
  logic [95:0] nb_q;
  logic [39:0] rem_q, den_q, maxv_q;
  logic [40:0] q_q;
  logic        ovf_q, busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [40:0] rem2, qn;
  logic        ge;

  assign rem2 = {rem_q, nb_q[95]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign qn   = {q_q[39:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64 + 7'(sh_i);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      nb_q   <= {num_i, 32'd0};
      rem_q  <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      den_q  <= den_i;
      maxv_q <= maxv_i;
    end else if (busy_q) begin
      nb_q  <= {nb_q[94:0], 1'b0};
      rem_q <= ge ? 40'(rem2 - {1'b0, den_q}) : rem2[39:0];
      q_q   <= qn;
      ovf_q <= ovf_q || (qn > {1'b0, maxv_q});
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = ovf_q ? maxv_q : q_q[39:0];
endmodule
`default_nettype wire

>>> hw/rtl/bpyd_back.sv
`default_nettype none
`include "bond_price_yield_duration_top_assert.svh"
module bpyd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     tol_i,
  input  logic            q_valid_i,
  input  bpyd_pkg::item_t q_item_i,
  output logic            q_pop_o,
  bpyd_out_if.source      res_o
);
  import bpyd_pkg::*;
  localparam int unsigned PRW = WW + 41;

  back_state_e state_q, state_d;

  item_t          it_q;
  logic [39:0]    c_q;
  logic [32:0]    low_q, high_q, d_q, v_q, p_q, pc_q;
  logic [31:0]    y_q, ytm_q, mac_q, mdur_q, cy_q;
  logic [39:0]    conv_q;
  logic [SW-1:0]  step_q;
  logic [63:0]    acc_q, pv_q, dacc_q, cacc_q;
  logic [NW-1:0]  t_q;
  logic [WW-1:0]  w_q;
  logic [40:0]    x_q, y2_q;
  logic [PRW-1:0] prod_q;
  logic [47:0]    price_q;
  logic           solving_q, conv_ok_q;
  logic           ovld_q;
  logic [47:0]    o_price;
  logic [31:0]    o_ytm, o_yu, o_mac, o_mdur, o_cy;
  logic [39:0]    o_conv;
  logic           o_conv_ok;
  logic [1:0]     o_status;

  logic [39:0] mul_a;
  logic [32:0] mul_b;
  logic [40:0] mul_res;
  logic        div_go, div_busy, div_done;
  logic [63:0] div_num;
  logic [5:0]  div_sh;
  logic [39:0] div_den, div_max, div_q;
  logic [WW-1:0] fac;
  logic [40:0] opnd;
  logic        out_load;
  logic [33:0] mid_sum;
  logic [31:0] mid_w, yu_w;
  logic [63:0] diff_w;
  logic        tol_hit;
  logic [64:0] csum;

  bpyd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  bpyd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (div_num),
    .sh_i   (div_sh),
    .den_i  (div_den),
    .maxv_i (div_max),
    .busy_o (div_busy),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign mid_w   = mid_sum[32:1];
  assign yu_w    = it_q.given ? it_q.req : ytm_q;
  assign diff_w  = ({24'd0, it_q.mkt} > pv_q) ? {24'd0, it_q.mkt} - pv_q
                                              : pv_q - {24'd0, it_q.mkt};
  assign tol_hit = diff_w < {48'd0, tol_i};
  assign csum    = {1'b0, cacc_q} + 65'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (res_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    div_go   = 1'b0;
    div_num  = '0;
    div_sh   = '0;
    div_den  = 40'd1;
    div_max  = MAX40;
    fac      = '0;
    opnd     = '0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = (q_item_i.status == ST_FREQ_ZERO) ? BK_OUT : BK_CMUL;
        end
      end
      BK_CMUL: begin
        mul_a   = it_q.face;
        mul_b   = {1'b0, it_q.crate};
        state_d = BK_CDIV;
      end
      BK_CDIV: begin
        div_go  = 1'b1;
        div_num = 64'(mul_res);
        div_den = 40'(it_q.f);
        state_d = BK_CWAIT;
      end
      BK_CWAIT: begin
        if (div_done) begin
          state_d = BK_BMID;
        end
      end
      BK_BMID: begin
        div_go  = 1'b1;
        div_num = 64'(mid_w);
        div_den = 40'(it_q.f);
        state_d = BK_RWAIT;
      end
      BK_RWAIT: begin
        if (div_done) begin
          div_go  = 1'b1;
          div_num = 64'(ONE_Q32);
          div_sh  = 6'd32;
          div_den = 40'(ONE_Q32 + 33'(div_q));
          state_d = BK_VWAIT;
        end
      end
      BK_VWAIT: begin
        if (div_done) begin
          state_d = (it_q.n == '0) ? BK_PFACE : BK_PMUL1;
        end
      end
      BK_PMUL1: begin
        mul_a   = 40'(p_q);
        mul_b   = v_q;
        state_d = BK_PMUL2;
      end
      BK_PMUL2: begin
        state_d = BK_PMUL3;
      end
      BK_PMUL3: begin
        mul_a   = c_q;
        mul_b   = p_q;
        state_d = BK_PACC;
      end
      BK_PACC: begin
        state_d = (t_q == it_q.n) ? BK_PFACE : BK_PMUL1;
      end
      BK_PFACE: begin
        mul_a   = it_q.face;
        mul_b   = p_q;
        state_d = BK_PEND;
      end
      BK_PEND: begin
        state_d = BK_PCHK;
      end
      BK_PCHK: begin
        if (solving_q) begin
          if (tol_hit || step_q == SW'(BISECT_STEPS - 1)) begin
            state_d = BK_FINAL;
          end else begin
            state_d = BK_BMID;
          end
        end else begin
          state_d = (it_q.status == ST_MKT_ZERO) ? BK_OUT : BK_DINIT;
        end
      end
      BK_FINAL: begin
        div_go  = 1'b1;
        div_num = 64'(yu_w);
        div_den = 40'(it_q.f);
        state_d = BK_RWAIT;
      end
      BK_DINIT: begin
        mul_a   = 40'(v_q);
        mul_b   = v_q;
        state_d = BK_DPC;
      end
      BK_DPC: begin
        state_d = (it_q.n == '0) ? BK_DF1 : BK_DM1;
      end
      BK_DM1: begin
        mul_a   = 40'(p_q);
        mul_b   = v_q;
        state_d = BK_DM2;
      end
      BK_DM2: begin
        mul_a   = 40'(pc_q);
        mul_b   = v_q;
        state_d = BK_DM3;
      end
      BK_DM3: begin
        mul_a   = c_q;
        mul_b   = p_q;
        state_d = BK_DM4;
      end
      BK_DM4: begin
        mul_a   = c_q;
        mul_b   = pc_q;
        state_d = BK_DM5;
      end
      BK_DM5: begin
        fac     = WW'(t_q);
        opnd    = x_q;
        state_d = BK_DM6;
      end
      BK_DM6: begin
        fac     = w_q;
        opnd    = y2_q;
        state_d = BK_DM7;
      end
      BK_DM7: begin
        state_d = (t_q == it_q.n) ? BK_DF1 : BK_DM1;
      end
      BK_DF1: begin
        mul_a   = it_q.face;
        mul_b   = p_q;
        state_d = BK_DF2;
      end
      BK_DF2: begin
        mul_a   = it_q.face;
        mul_b   = pc_q;
        state_d = BK_DF3;
      end
      BK_DF3: begin
        fac     = WW'(it_q.n);
        opnd    = x_q;
        state_d = BK_DF4;
      end
      BK_DF4: begin
        fac     = (it_q.n == '0) ? '0 : w_q;
        opnd    = y2_q;
        state_d = BK_DF5;
      end
      BK_DF5: begin
        state_d = BK_MAC;
      end
      BK_MAC: begin
        div_go  = 1'b1;
        div_num = dacc_q;
        div_sh  = 6'd16;
        div_den = it_q.mkt;
        div_max = MAX32;
        state_d = BK_MACW;
      end
      BK_MACW: begin
        if (div_done) begin
          div_go  = 1'b1;
          div_num = 64'(div_q[31:0]);
          div_sh  = 6'd32;
          div_den = 40'(d_q);
          div_max = MAX32;
          state_d = BK_MDW;
        end
      end
      BK_MDW: begin
        if (div_done) begin
          div_go  = 1'b1;
          div_num = cacc_q;
          div_sh  = 6'd16;
          div_den = it_q.mkt;
          div_max = MAX40;
          state_d = BK_CVW;
        end
      end
      BK_CVW: begin
        if (div_done) begin
          div_go  = 1'b1;
          div_num = 64'(c_q);
          div_sh  = 6'd24;
          div_den = it_q.mkt;
          div_max = MAX32;
          state_d = BK_CYW;
        end
      end
      BK_CYW: begin
        if (div_done) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!ovld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PRW'(fac) * PRW'(opnd);
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          it_q <= q_item_i;
        end
      end
      BK_CWAIT: begin
        if (div_done) begin
          c_q       <= div_q;
          low_q     <= '0;
          high_q    <= ONE_Q32;
          step_q    <= '0;
          solving_q <= 1'b1;
          conv_ok_q <= 1'b0;
        end
      end
      BK_BMID: begin
        y_q <= mid_w;
      end
      BK_RWAIT: begin
        if (div_done) begin
          d_q <= ONE_Q32 + 33'(div_q);
        end
      end
      BK_VWAIT: begin
        if (div_done) begin
          v_q   <= div_q[32:0];
          p_q   <= ONE_Q32;
          acc_q <= '0;
          t_q   <= NW'(1);
        end
      end
      BK_PMUL2: begin
        p_q <= mul_res[32:0];
      end
      BK_PACC: begin
        acc_q <= acc_q + 64'(mul_res);
        t_q   <= t_q + 1'b1;
      end
      BK_PEND: begin
        pv_q <= acc_q + 64'(mul_res);
      end
      BK_PCHK: begin
        if (solving_q) begin
          if (tol_hit) begin
            conv_ok_q <= 1'b1;
            ytm_q     <= y_q;
          end else begin
            if (pv_q < {24'd0, it_q.mkt}) begin
              high_q <= {1'b0, y_q};
            end else begin
              low_q <= {1'b0, y_q};
            end
            step_q <= step_q + 1'b1;
            ytm_q  <= y_q;
          end
        end else begin
          price_q <= (pv_q > 64'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : pv_q[47:0];
        end
      end
      BK_FINAL: begin
        y_q       <= yu_w;
        solving_q <= 1'b0;
      end
      BK_DINIT: begin
        p_q <= ONE_Q32;
      end
      BK_DPC: begin
        pc_q   <= mul_res[32:0];
        t_q    <= NW'(1);
        w_q    <= WW'(2);
        dacc_q <= '0;
        cacc_q <= '0;
      end
      BK_DM2: begin
        p_q <= mul_res[32:0];
      end
      BK_DM3: begin
        pc_q <= mul_res[32:0];
      end
      BK_DM4, BK_DF2: begin
        x_q <= mul_res;
      end
      BK_DM5, BK_DF3: begin
        y2_q <= mul_res;
      end
      BK_DM6, BK_DF4: begin
        dacc_q <= dacc_q + 64'(prod_q);
      end
      BK_DM7: begin
        cacc_q <= csum[64] ? '1 : csum[63:0];
        if (t_q != it_q.n) begin
          t_q <= t_q + 1'b1;
          w_q <= w_q + WW'({t_q, 1'b0}) + WW'(2);
        end
      end
      BK_DF5: begin
        cacc_q <= csum[64] ? '1 : csum[63:0];
      end
      BK_MACW: begin
        if (div_done) begin
          mac_q <= div_q[31:0];
        end
      end
      BK_MDW: begin
        if (div_done) begin
          mdur_q <= div_q[31:0];
        end
      end
      BK_CVW: begin
        if (div_done) begin
          conv_q <= div_q;
        end
      end
      BK_CYW: begin
        if (div_done) begin
          cy_q <= div_q[31:0];
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      o_status <= it_q.status;
      if (it_q.status == ST_FREQ_ZERO) begin
        o_price   <= '0;
        o_ytm     <= '0;
        o_yu      <= '0;
        o_conv_ok <= 1'b0;
      end else begin
        o_price   <= price_q;
        o_ytm     <= ytm_q;
        o_yu      <= y_q;
        o_conv_ok <= conv_ok_q;
      end
      if (it_q.status == ST_OK) begin
        o_mac  <= mac_q;
        o_mdur <= mdur_q;
        o_conv <= conv_q;
        o_cy   <= cy_q;
      end else begin
        o_mac  <= '0;
        o_mdur <= '0;
        o_conv <= '0;
        o_cy   <= '0;
      end
    end
  end

  assign res_o.valid             = ovld_q;
  assign res_o.price             = o_price;
  assign res_o.yield_to_maturity = o_ytm;
  assign res_o.yield_used        = o_yu;
  assign res_o.mac_duration      = o_mac;
  assign res_o.modified_duration = o_mdur;
  assign res_o.convexity         = o_conv;
  assign res_o.current_yield     = o_cy;
  assign res_o.solve_converged   = o_conv_ok;
  assign res_o.status            = o_status;

  `BPYD_ASSERT(a_div_go_idle, div_go |-> !div_busy, "divider restarted while busy")
  `BPYD_ASSERT(a_out_no_overwrite, out_load |-> (!ovld_q || res_o.ready), "result overwritten")
  `BPYD_ASSERT_NEVER(a_pop_busy, q_pop_o && (state_q != BK_IDLE), "queue popped mid item")
endmodule
`default_nettype wire

>>> hw/rtl/bond_price_yield_duration_top.sv
// Bond pricing engine: price, yield to maturity, durations, convexity, current yield.
// in_i  : one bond per transaction (valid/ready). A two-entry queue sits behind the
//         input, so up to two bonds are taken while the engine is busy.
// res_o : one result per bond, in order, held in an output register until ready.
// cfg   : cfg_we_i writes cfg_wdata_i into the price tolerance (reset value 1).
//         Write only while the block is idle.
// Each bond runs a bisection on the yield, of up to 32 steps, each pricing all n
// periods (n up to 768), then a duration pass over the same periods. With zero
// market price the duration pass is skipped. A bond with zero payments per year
// goes straight to the output stage.
// One bond is worked at a time; the next is taken from the queue only after the
// result is loaded. The engine shares one 40x33 multiplier (one product per cycle)
// and a one-bit-per-cycle divider.
// Reset clears the queue, the engine state and the output valid.
// A stalled receiver holds the result; the engine then waits with its next result
// done and the queue keeps accepting until full.
`default_nettype none
module bond_price_yield_duration_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  bpyd_in_if.sink     in_i,
  bpyd_out_if.source  res_o
);
  import bpyd_pkg::*;

  logic [15:0] tol_q;
  logic        push, full, qvalid, pop;
  item_t       push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  bpyd_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  bpyd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .item_o  (head_item)
  );

  bpyd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tol_i     (tol_q),
    .q_valid_i (qvalid),
    .q_item_i  (head_item),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );
endmodule
`default_nettype wire
